>>> hw/rtl/ps2_mouse_cursor_tracker_defines.svh
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_CURSOR_TRACKER_DEFINES_SVH
`define PS2_MOUSE_CURSOR_TRACKER_DEFINES_SVH

// hold a condition at every edge
`define PS2MCT_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ps2mct assertion failed");

// check a consequence in the cycle after the antecedent
`define PS2MCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ps2mct assertion failed");

`endif

>>> hw/rtl/ps2mct_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker package
// Widths, reset values, register indexes, input kinds and held-byte states.
// ----------------------------------------------------------------------------
`default_nettype none

package ps2mct_pkg;

  localparam int unsigned PosW   = 10;
  localparam int unsigned WheelW = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned TickW  = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;

  localparam int unsigned InDataW  = 8;
  localparam int unsigned InUserW  = 1;
  localparam int unsigned OutDataW = 48;
  localparam int unsigned OutUserW = 3;

  localparam logic [PosW-1:0]  XLimitRst = PosW'(639);
  localparam logic [PosW-1:0]  YLimitRst = PosW'(479);
  localparam logic [TickW-1:0] ResyncRst = TickW'(20);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_X_LIMIT      = 2'd0,
    CFG_Y_LIMIT      = 2'd1,
    CFG_RESYNC_TICKS = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_TICK = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    HELD_NONE   = 2'd0,
    HELD_HEADER = 2'd1,
    HELD_X      = 2'd2,
    HELD_Y      = 2'd3
  } held_e;

endpackage

`default_nettype wire

>>> hw/rtl/ps2_mouse_cursor_tracker.sv
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker
// Packet assembly, cursor clamping, wheel total and stall resync.
// ----------------------------------------------------------------------------
// Usage:
//   Input words carry a mouse byte (tuser = 0) or a frame tick (tuser = 1).
//   Every accepted input word yields exactly one output word with the
//   cursor position, wheel total, button byte and the done/resync/mode flags.
//   The word accepted at an edge is on the output channel right after it.
//   Throughput is one word per cycle while the receiver takes every result,
//   set by the single state/result register stage, also the output buffer.
//   A new word is taken while the current result is being taken, so a
//   receiver that takes every cycle never stalls the sender.
//   When the receiver stalls, the result holds and s_axis_tready falls
//   until the pending word is taken.
//   Reset clears all tracking state, drops any pending result and loads the
//   limits 639 / 479 and a resync threshold of 20 ticks.
//   Configuration: pulse cfg_we_i with cfg_idx_i (0 x_limit, 1 y_limit,
//   2 resync_ticks) and cfg_wdata_i while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ps2_mouse_cursor_tracker_defines.svh"

module ps2_mouse_cursor_tracker
  import ps2mct_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,  // [7:0] data_byte
  input  wire logic [InUserW-1:0]  s_axis_tuser,  // [0] kind
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,  // [9:0] cursor_x, [19:10] cursor_y,
                                                  // [35:20] wheel_total,
                                                  // [43:36] button_bits, [47:44] zero
  output logic [OutUserW-1:0]      m_axis_tuser   // [0] packet_done, [1] resynced,
                                                  // [2] four_byte_mode
);

  logic [PosW-1:0]   x_limit_q, y_limit_q;
  logic [TickW-1:0]  resync_ticks_q;

  logic              wheel_mode_q, wheel_mode_d;
  held_e             bytes_held_q, bytes_held_d;
  logic [ByteW-1:0]  header_byte_q, header_byte_d;
  logic [ByteW-1:0]  x_delta_byte_q, x_delta_byte_d;
  logic [ByteW-1:0]  y_delta_byte_q, y_delta_byte_d;
  logic [PosW-1:0]   pos_x_q, pos_x_d;
  logic [PosW-1:0]   pos_y_q, pos_y_d;
  logic [WheelW-1:0] wheel_sum_q, wheel_sum_d;
  logic [ByteW-1:0]  buttons_held_q, buttons_held_d;
  logic [TickW-1:0]  stall_ticks_q, stall_ticks_d;
  logic              done_q, done_d;
  logic              resync_q, resync_d;
  logic              out_valid_q, out_valid_d;

  logic              accept;
  kind_e             kind;
  logic [ByteW-1:0]  in_byte;
  logic [ByteW-1:0]  y_byte;
  logic [PosW+1:0]   sum_x, sum_y;
  logic [PosW-1:0]   new_x, new_y;
  logic [WheelW-1:0] wheel_next;
  logic [TickW-1:0]  stall_inc;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign kind    = kind_e'(s_axis_tuser[0]);
  assign in_byte = s_axis_tdata;

  assign y_byte = (bytes_held_q == HELD_X) ? in_byte : y_delta_byte_q;
  assign sum_x  = {2'b00, pos_x_q} + {{(PosW+2-ByteW){header_byte_q[4]}}, x_delta_byte_q};
  assign sum_y  = {2'b00, pos_y_q} - {{(PosW+2-ByteW){header_byte_q[5]}}, y_byte};

  always_comb begin
    if (sum_x[PosW+1]) begin
      new_x = '0;
    end else if (sum_x[PosW:0] > {1'b0, x_limit_q}) begin
      new_x = x_limit_q;
    end else begin
      new_x = sum_x[PosW-1:0];
    end
    if (sum_y[PosW+1]) begin
      new_y = '0;
    end else if (sum_y[PosW:0] > {1'b0, y_limit_q}) begin
      new_y = y_limit_q;
    end else begin
      new_y = sum_y[PosW-1:0];
    end
  end

  assign wheel_next = wheel_sum_q + {{(WheelW-4){in_byte[3]}}, in_byte[3:0]};
  assign stall_inc  = stall_ticks_q + TickW'(1);

  always_comb begin
    wheel_mode_d   = wheel_mode_q;
    bytes_held_d   = bytes_held_q;
    header_byte_d  = header_byte_q;
    x_delta_byte_d = x_delta_byte_q;
    y_delta_byte_d = y_delta_byte_q;
    pos_x_d        = pos_x_q;
    pos_y_d        = pos_y_q;
    wheel_sum_d    = wheel_sum_q;
    buttons_held_d = buttons_held_q;
    stall_ticks_d  = stall_ticks_q;
    done_d         = done_q;
    resync_d       = resync_q;
    out_valid_d    = out_valid_q && !m_axis_tready;
    if (accept) begin
      out_valid_d = 1'b1;
      done_d      = 1'b0;
      resync_d    = 1'b0;
      if (kind == KIND_BYTE) begin
        case (bytes_held_q)
          HELD_NONE: begin
            header_byte_d = in_byte;
            bytes_held_d  = HELD_HEADER;
          end
          HELD_HEADER: begin
            x_delta_byte_d = in_byte;
            bytes_held_d   = HELD_X;
          end
          HELD_X: begin
            y_delta_byte_d = in_byte;
            if (wheel_mode_q) begin
              bytes_held_d = HELD_Y;
            end else begin
              buttons_held_d = header_byte_q;
              pos_x_d        = new_x;
              pos_y_d        = new_y;
              bytes_held_d   = HELD_NONE;
              stall_ticks_d  = '0;
              done_d         = 1'b1;
            end
          end
          HELD_Y: begin
            buttons_held_d = header_byte_q;
            pos_x_d        = new_x;
            pos_y_d        = new_y;
            if (wheel_mode_q) begin
              wheel_sum_d = wheel_next;
            end
            bytes_held_d  = HELD_NONE;
            stall_ticks_d = '0;
            done_d        = 1'b1;
          end
          default: begin
            bytes_held_d = HELD_NONE;
          end
        endcase
      end else if (bytes_held_q != HELD_NONE) begin
        stall_ticks_d = stall_inc;
        if (stall_inc >= resync_ticks_q) begin
          bytes_held_d  = HELD_NONE;
          stall_ticks_d = '0;
          wheel_mode_d  = !wheel_mode_q;
          resync_d      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_limit_q      <= XLimitRst;
      y_limit_q      <= YLimitRst;
      resync_ticks_q <= ResyncRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_X_LIMIT:      x_limit_q      <= cfg_wdata_i;
        CFG_Y_LIMIT:      y_limit_q      <= cfg_wdata_i;
        CFG_RESYNC_TICKS: resync_ticks_q <= cfg_wdata_i[TickW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_mode_q   <= 1'b0;
      bytes_held_q   <= HELD_NONE;
      header_byte_q  <= '0;
      x_delta_byte_q <= '0;
      y_delta_byte_q <= '0;
      pos_x_q        <= '0;
      pos_y_q        <= '0;
      wheel_sum_q    <= '0;
      buttons_held_q <= '0;
      stall_ticks_q  <= '0;
      done_q         <= 1'b0;
      resync_q       <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      wheel_mode_q   <= wheel_mode_d;
      bytes_held_q   <= bytes_held_d;
      header_byte_q  <= header_byte_d;
      x_delta_byte_q <= x_delta_byte_d;
      y_delta_byte_q <= y_delta_byte_d;
      pos_x_q        <= pos_x_d;
      pos_y_q        <= pos_y_d;
      wheel_sum_q    <= wheel_sum_d;
      buttons_held_q <= buttons_held_d;
      stall_ticks_q  <= stall_ticks_d;
      done_q         <= done_d;
      resync_q       <= resync_d;
      out_valid_q    <= out_valid_d;
    end
  end

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, buttons_held_q, wheel_sum_q, pos_y_q, pos_x_q};
  assign m_axis_tuser  = {wheel_mode_q, resync_q, done_q};

  `PS2MCT_ASSERT(a_done_resync_excl, !(done_q && resync_q))
  `PS2MCT_ASSERT(a_wheel_byte_mode, (bytes_held_q != HELD_Y) || wheel_mode_q)
  `PS2MCT_ASSERT_NEXT(a_resync_toggles, accept && resync_d,
                      wheel_mode_q != $past(wheel_mode_q) && bytes_held_q == HELD_NONE)
  `PS2MCT_ASSERT_NEXT(a_tick_no_done, accept && kind == KIND_TICK, !done_q)
  `PS2MCT_ASSERT_NEXT(a_byte_no_resync, accept && kind == KIND_BYTE,
                      !resync_q && wheel_mode_q == $past(wheel_mode_q))

endmodule

`default_nettype wire

>>> verif/ps2_mouse_cursor_tracker_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker testbench
// Streams mouse bytes and frame ticks into the tracker and checks every
// output word against a cycle-free model of packet assembly, cursor clamping,
// wheel accumulation and stall resync. Starts with a short directed run,
// then runs random phases under different limit and threshold settings, with
// sender bursts and gaps and receiver stalls.
// ----------------------------------------------------------------------------
module ps2_mouse_cursor_tracker_test;
  import ps2mct_pkg::*;

  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned RandomItems = 1950;
  localparam int unsigned Phases      = 8;
  localparam int unsigned MaxReports  = 40;

  typedef struct {
    logic [PosW-1:0]   cx;
    logic [PosW-1:0]   cy;
    logic [WheelW-1:0] wheel;
    logic [ByteW-1:0]  buttons;
    logic              done;
    logic              resync;
    logic              mode;
  } cursor_report_t;

  class cursor_board;
    cursor_report_t   pending[$];
    int unsigned      errors;
    int unsigned      packets;
    int unsigned      resyncs;
    logic [PosW-1:0]  x_lim;
    logic [PosW-1:0]  y_lim;
    logic [TickW-1:0] thr;
    logic             wheel_mode;
    held_e            held;
    logic [ByteW-1:0] header;
    logic [ByteW-1:0] x_byte;
    logic [ByteW-1:0] y_byte;
    logic [PosW-1:0]  pos_x;
    logic [PosW-1:0]  pos_y;
    logic [WheelW-1:0] wheel;
    logic [ByteW-1:0] buttons;
    logic [TickW-1:0] stall;

    function new();
      errors     = 0;
      packets    = 0;
      resyncs    = 0;
      x_lim      = XLimitRst;
      y_lim      = YLimitRst;
      thr        = ResyncRst;
      wheel_mode = 1'b0;
      held       = HELD_NONE;
      header     = '0;
      x_byte     = '0;
      y_byte     = '0;
      pos_x      = '0;
      pos_y      = '0;
      wheel      = '0;
      buttons    = '0;
      stall      = '0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_X_LIMIT: x_lim = val;
        CFG_Y_LIMIT: y_lim = val;
        CFG_RESYNC_TICKS: thr = val[TickW-1:0];
        default: ;
      endcase
    endfunction

    function void close_packet(logic [ByteW-1:0] wheel_byte);
      int dx;
      int dy;
      int nx;
      int ny;
      logic [3:0] nib;
      dx = int'(x_byte);
      dy = int'(y_byte);
      if (header[4]) dx -= 256;
      if (header[5]) dy -= 256;
      nx = int'(pos_x) + dx;
      ny = int'(pos_y) - dy;
      if (nx < 0) pos_x = '0;
      else if (nx > int'(x_lim)) pos_x = x_lim;
      else pos_x = PosW'(nx);
      if (ny < 0) pos_y = '0;
      else if (ny > int'(y_lim)) pos_y = y_lim;
      else pos_y = PosW'(ny);
      buttons = header;
      if (wheel_mode) begin
        nib = wheel_byte[3:0];
        wheel = wheel + {{(WheelW-4){nib[3]}}, nib};
      end
      held  = HELD_NONE;
      stall = '0;
      packets++;
    endfunction

    function void accept_input(kind_e kind, logic [ByteW-1:0] data);
      cursor_report_t rep;
      rep.done   = 1'b0;
      rep.resync = 1'b0;
      if (kind == KIND_BYTE) begin
        case (held)
          HELD_NONE: begin
            header = data;
            held   = HELD_HEADER;
          end
          HELD_HEADER: begin
            x_byte = data;
            held   = HELD_X;
          end
          HELD_X: begin
            y_byte = data;
            if (wheel_mode) begin
              held = HELD_Y;
            end else begin
              close_packet(8'h00);
              rep.done = 1'b1;
            end
          end
          default: begin
            close_packet(data);
            rep.done = 1'b1;
          end
        endcase
      end else if (held != HELD_NONE) begin
        stall = stall + 1'b1;
        if (stall >= thr) begin
          held       = HELD_NONE;
          stall      = '0;
          wheel_mode = ~wheel_mode;
          rep.resync = 1'b1;
          resyncs++;
        end
      end
      rep.cx      = pos_x;
      rep.cy      = pos_y;
      rep.wheel   = wheel;
      rep.buttons = buttons;
      rep.mode    = wheel_mode;
      pending.push_back(rep);
    endfunction

    function void compare_field(string name, logic [WheelW-1:0] want,
                                logic [WheelW-1:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t %s: expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_report(logic [OutDataW-1:0] d, logic [OutUserW-1:0] u);
      cursor_report_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t output word with none expected: expected none, actual %0h/%0h",
                   $time, d, u);
        return;
      end
      want = pending.pop_front();
      compare_field("cursor_x", WheelW'(want.cx), WheelW'(d[9:0]));
      compare_field("cursor_y", WheelW'(want.cy), WheelW'(d[19:10]));
      compare_field("wheel_total", want.wheel, d[35:20]);
      compare_field("button_bits", WheelW'(want.buttons), WheelW'(d[43:36]));
      compare_field("packet_done", WheelW'(want.done), WheelW'(u[0]));
      compare_field("resynced", WheelW'(want.resync), WheelW'(u[1]));
      compare_field("four_byte_mode", WheelW'(want.mode), WheelW'(u[2]));
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;   // [7:0] data_byte
  logic [InUserW-1:0]  s_axis_tuser;   // [0] kind
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // [9:0] cursor_x, [19:10] cursor_y,
                                       // [35:20] wheel_total, [43:36] button_bits
  logic [OutUserW-1:0] m_axis_tuser;   // [0] packet_done, [1] resynced,
                                       // [2] four_byte_mode

  cursor_board board = new();
  int unsigned burst_left;
  int unsigned items_sent;
  int unsigned settings_used;
  bit          gaps_on;

  ps2_mouse_cursor_tracker u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk_i);
    $display("timeout after %0d cycles", CycleLimit);
    $display("ps2_mouse_cursor_tracker: mismatch");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_report(m_axis_tdata, m_axis_tuser);
  end

  initial begin : receiver
    int unsigned style;
    logic [7:0]  mask;
    m_axis_tready = 1'b0;
    style = 0;
    mask  = 8'b1011_0010;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 99) == 0) style = $urandom_range(0, 3);
      mask = {mask[0], mask[7:1]};
      case (style)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= mask[0];
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic send_word(kind_e kind, logic [ByteW-1:0] data);
    int unsigned gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    items_sent++;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    board.accept_input(kind, data);
  endtask

  task automatic wait_all_reported();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_reg(idx, val);
  endtask

  // a tick may slip in before any byte; tick_pct is its chance in percent
  task automatic send_packet(logic [7:0] hdr, logic [7:0] dx, logic [7:0] dy,
                             logic [7:0] wh, int unsigned tick_pct);
    logic [7:0] bytes [4];
    int unsigned len;
    bytes = '{hdr, dx, dy, wh};
    len = board.wheel_mode ? 4 : 3;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < tick_pct) send_word(KIND_TICK, 8'($urandom));
      send_word(KIND_BYTE, bytes[i]);
    end
  endtask

  function automatic logic [7:0] pick_delta();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic run_phase(int unsigned quota);
    int unsigned start;
    int unsigned pick;
    int unsigned n;
    int unsigned ticks;
    int unsigned eff_thr;
    bit          long_done;
    bit          half_done;
    start     = items_sent;
    long_done = 1'b0;
    half_done = 1'b0;
    gaps_on   = ($urandom_range(0, 3) != 0);
    while (items_sent - start < quota) begin
      if (!half_done && items_sent - start >= quota / 2) begin
        wait_all_reported();
        half_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_packet(8'($urandom), pick_delta(), pick_delta(), 8'($urandom), 8);
      end else if (pick < 80) begin
        n = $urandom_range(1, board.wheel_mode ? 3 : 2);
        repeat (n) send_word(KIND_BYTE, 8'($urandom));
        eff_thr = (board.thr == 0) ? 1 : board.thr;
        if (eff_thr > 40 && long_done) begin
          ticks = $urandom_range(1, 40);
        end else begin
          ticks = eff_thr;
          long_done = 1'b1;
        end
        repeat (ticks) send_word(KIND_TICK, 8'($urandom));
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 3)) send_word(KIND_TICK, 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) send_word(kind_e'($urandom_range(0, 1)), 8'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_X_LIMIT;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_BYTE;
    gaps_on       = 1'b0;
    burst_left    = 0;
    items_sent    = 0;
    settings_used = 1;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    send_word(KIND_TICK, 8'hFF);
    send_packet(8'h08, 8'h7F, 8'h00, 8'h00, 0);
    send_packet(8'h38, 8'h80, 8'h80, 8'h00, 0);
    send_packet(8'h00, 8'hFF, 8'h01, 8'h00, 0);
    wait_all_reported();
    write_reg(CFG_RESYNC_TICKS, 10'd2);
    write_reg(CFG_UNUSED, 10'h3FF);
    settings_used++;
    send_word(KIND_BYTE, 8'h09);
    send_word(KIND_TICK, 8'h00);
    send_word(KIND_BYTE, 8'h10);
    send_word(KIND_TICK, 8'h55);
    send_packet(8'h08, 8'h01, 8'h02, 8'hFF, 0);
    send_packet(8'h30, 8'h00, 8'h00, 8'hF8, 0);
    wait_all_reported();
    write_reg(CFG_Y_LIMIT, 10'd5);
    write_reg(CFG_RESYNC_TICKS, 10'h300);
    settings_used++;
    send_word(KIND_BYTE, 8'h00);
    send_word(KIND_TICK, 8'hAA);
    send_packet(8'h00, 8'h00, 8'h00, 8'h00, 0);

    for (int p = 0; p < Phases; p++) begin
      wait_all_reported();
      case (p)
        0: begin
          write_reg(CFG_X_LIMIT, 10'd1023);
          write_reg(CFG_Y_LIMIT, 10'd1023);
          write_reg(CFG_RESYNC_TICKS, 10'd1);
        end
        1: begin
          write_reg(CFG_X_LIMIT, 10'd0);
          write_reg(CFG_Y_LIMIT, 10'd0);
          write_reg(CFG_RESYNC_TICKS, 10'd255);
        end
        2: begin
          write_reg(CFG_X_LIMIT, 10'd639);
          write_reg(CFG_Y_LIMIT, 10'd479);
          write_reg(CFG_RESYNC_TICKS, 10'd20);
        end
        3: begin
          write_reg(CFG_X_LIMIT, 10'd1);
          write_reg(CFG_Y_LIMIT, 10'd1022);
          write_reg(CFG_RESYNC_TICKS, 10'h300);
        end
        default: begin
          write_reg(CFG_X_LIMIT, 10'($urandom));
          write_reg(CFG_Y_LIMIT, 10'($urandom));
          write_reg(CFG_RESYNC_TICKS, {2'($urandom), 8'($urandom_range(1, 12))});
          write_reg(CFG_UNUSED, 10'($urandom));
        end
      endcase
      settings_used++;
      run_phase(RandomItems / Phases);
    end

    wait_all_reported();
    repeat (8) @(posedge clk_i);
    $display("sent %0d input words under %0d register settings", items_sent, settings_used);
    $display("saw %0d complete packets and %0d stall resyncs", board.packets, board.resyncs);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("ps2_mouse_cursor_tracker: match");
    end else begin
      $display("ps2_mouse_cursor_tracker: mismatch");
    end
    $finish;
  end

endmodule
